// File: src/etl_pkg.sv
package etl_pkg;

  localparam int unsigned TokenLengthLimit = 255;
  localparam int unsigned CountW           = $clog2(TokenLengthLimit + 1);

  localparam int unsigned CharW    = 8;
  localparam int unsigned LenW     = 8;
  localparam int unsigned ClassW   = 3;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned NumSep   = 4;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  // token classes
  localparam logic [ClassW-1:0] ClassInt   = 3'd0;
  localparam logic [ClassW-1:0] ClassOctal = 3'd1;
  localparam logic [ClassW-1:0] ClassFloat = 3'd2;
  localparam logic [ClassW-1:0] ClassName  = 3'd3;
  localparam logic [ClassW-1:0] ClassOper  = 3'd4;

  // result kinds
  localparam logic [KindW-1:0] KindChar = 2'd0;
  localparam logic [KindW-1:0] KindEnd  = 2'd1;
  localparam logic [KindW-1:0] KindDone = 2'd2;

  localparam logic [CharW-1:0] ChQuote = 8'd34;
  localparam logic [CharW-1:0] ChPct   = 8'd37;
  localparam logic [CharW-1:0] ChLpar  = 8'd40;
  localparam logic [CharW-1:0] ChRpar  = 8'd41;
  localparam logic [CharW-1:0] ChStar  = 8'd42;
  localparam logic [CharW-1:0] ChPlus  = 8'd43;
  localparam logic [CharW-1:0] ChMinus = 8'd45;
  localparam logic [CharW-1:0] ChDot   = 8'd46;
  localparam logic [CharW-1:0] ChSlash = 8'd47;
  localparam logic [CharW-1:0] ChZero  = 8'd48;
  localparam logic [CharW-1:0] ChSeven = 8'd55;
  localparam logic [CharW-1:0] ChNine  = 8'd57;
  localparam logic [CharW-1:0] ChEq    = 8'd61;

  typedef logic [NumSep-1:0][CharW-1:0] sep_vec_t;
  // entry 0 is separator_one
  localparam sep_vec_t SepReset = {8'd0, 8'd0, 8'd9, 8'd32};

  // results caused by one input word, sent in field order top to bottom
  typedef struct packed {
    logic              end_v;
    logic [ClassW-1:0] end_class;
    logic [LenW-1:0]   end_len;
    logic              echo_v;
    logic [CharW-1:0]  ch;
    logic              op_v;
    logic              done_v;
    logic              unterm;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_operator(logic [CharW-1:0] c);
    return (c == ChEq) || (c == ChPlus) || (c == ChMinus) || (c == ChStar) ||
           (c == ChSlash) || (c == ChPct) || (c == ChLpar) || (c == ChRpar);
  endfunction

endpackage

// File: src/expression_token_lexer.sv
// Character stream lexer for one line of an expression language.
// Slave stream: one character per word in tdata[7:0]; tlast set marks end
// of line (the character is then ignored). Master stream: one result per
// word, tuser gives its kind (token character, token end, line done) and
// tlast flags the last result caused by one input word.
// Configuration: cfg_valid_i with cfg_index_i 0..3 writes the four
// separator characters (zero disables one); always ready, write only
// while the lexer is idle.
// Results enter the queue when their input word is taken and leave from
// its head. Throughput: one input word per cycle while the output
// keeps up; a word makes up to three results and the master side sends
// one per cycle, so operator bursts are absorbed by a four-entry queue
// between the classifying front end and the result sequencer.
// When the receiver stalls, the queue fills and s_axis_tready drops once
// all four entries hold pending results; the held result stays stable.
// Reset empties the queue, clears the token state and sets the
// separators to space and tab.
module expression_token_lexer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] character
  input  logic                          s_axis_tlast,  // end_of_line
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // [7:0] token_char,
                                        // [10:8] token_class, [18:11] token_length,
                                        // [19] unterminated_quote, [23:20] zero
  output logic [etl_pkg::KindW-1:0]     m_axis_tuser,  // [1:0] result_kind
  output logic                          m_axis_tlast,  // last_of_run
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [etl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [etl_pkg::CharW-1:0]     cfg_data_i
);
  import etl_pkg::*;

  entry_t            push_entry, head_entry;
  q_status_t         q_status;
  logic              push, pop;
  logic [CharW-1:0]  tok_char;
  logic [ClassW-1:0] tok_class;
  logic [LenW-1:0]   tok_len;
  logic              unterm;

  assign cfg_ready_o = 1'b1;

  etl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_char_i   (s_axis_tdata),
    .in_eol_i    (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  etl_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .status_o (q_status)
  );

  etl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (head_entry),
    .q_status_i (q_status),
    .pop_o      (pop),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .kind_o     (m_axis_tuser),
    .char_o     (tok_char),
    .class_o    (tok_class),
    .len_o      (tok_len),
    .unterm_o   (unterm),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, unterm, tok_len, tok_class, tok_char};

  // line done is always the final result of its input word
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KindDone)) |-> m_axis_tlast)
    else $error("line done not marked last");

  a_unterm_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && unterm) |-> (m_axis_tuser == KindDone))
    else $error("unterminated flag outside line done");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("result queue overflow");

  a_kind_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KindChar)) |-> (tok_len == '0 && tok_class == ClassInt))
    else $error("token character carries end fields");

endmodule

// File: src/etl_front.sv
module etl_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [etl_pkg::CharW-1:0] in_char_i,
  input  logic                    in_eol_i,
  output logic                    in_ready_o,
  input  logic                    cfg_valid_i,
  input  logic [etl_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [etl_pkg::CharW-1:0] cfg_data_i,
  input  etl_pkg::q_status_t      q_status_i,
  output logic                    push_o,
  output etl_pkg::entry_t         entry_o
);
  import etl_pkg::*;

  sep_vec_t sep_q, sep_d;
  logic              in_quote_q, in_quote_d;
  logic [CountW-1:0] count_q, count_d;
  logic              zero_q, zero_d;
  logic              digits_q, digits_d;
  logic              below8_q, below8_d;
  logic              tail_q, tail_d;

  logic              accept;
  logic              is_sep;
  logic              is_op;
  logic              is_digit;
  logic [ClassW-1:0] word_class;
  logic [LenW-1:0]   rep_len;
  logic [CountW-1:0] count_inc;
  entry_t            ent;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign is_digit   = (in_char_i >= ChZero) && (in_char_i <= ChNine);
  assign is_op      = is_operator(in_char_i);

  always_comb begin
    is_sep = 1'b0;
    for (int i = 0; i < NumSep; i++) begin
      if ((sep_q[i] != '0) && (in_char_i == sep_q[i])) is_sep = 1'b1;
    end
  end

  always_comb begin
    if (digits_q) word_class = (zero_q && below8_q) ? ClassOctal : ClassInt;
    else          word_class = tail_q ? ClassFloat : ClassName;
  end

  assign rep_len   = (count_q > CountW'(255)) ? '1 : LenW'(count_q);
  assign count_inc = (count_q < CountW'(TokenLengthLimit)) ? count_q + 1'b1 : count_q;

  always_comb begin
    sep_d = sep_q;
    if (cfg_valid_i) begin
      for (int i = 0; i < NumSep; i++) begin
        if (cfg_index_i == CfgIdxW'(i)) sep_d[i] = cfg_data_i;
      end
    end
  end

  always_comb begin
    ent        = '0;
    in_quote_d = in_quote_q;
    count_d    = count_q;
    zero_d     = zero_q;
    digits_d   = digits_q;
    below8_d   = below8_q;
    tail_d     = tail_q;
    if (in_eol_i) begin
      ent.end_v     = in_quote_q || (count_q != '0);
      ent.end_class = in_quote_q ? ClassName : word_class;
      ent.end_len   = rep_len;
      ent.done_v    = 1'b1;
      ent.unterm    = in_quote_q;
      in_quote_d    = 1'b0;
    end else if (in_quote_q) begin
      if (in_char_i == ChQuote) begin
        ent.end_v     = 1'b1;
        ent.end_class = ClassName;
        ent.end_len   = rep_len;
        in_quote_d    = 1'b0;
      end else begin
        ent.echo_v = 1'b1;
        ent.ch     = in_char_i;
        count_d    = count_inc;
      end
    end else if (in_char_i == ChQuote) begin
      in_quote_d = 1'b1;
    end else if (is_op || is_sep) begin
      // an operator wins even when it is also a separator
      ent.end_v     = (count_q != '0);
      ent.end_class = word_class;
      ent.end_len   = rep_len;
      ent.echo_v    = is_op;
      ent.ch        = is_op ? in_char_i : '0;
      ent.op_v      = is_op;
    end else begin
      ent.echo_v = 1'b1;
      ent.ch     = in_char_i;
      if (count_q == '0) zero_d = (in_char_i == ChZero);
      if (digits_q) begin
        if (is_digit) begin
          if (in_char_i > ChSeven) below8_d = 1'b0;
        end else begin
          digits_d = 1'b0;
          tail_d   = (in_char_i == ChDot);
        end
      end else if (!is_digit && (in_char_i != ChDot)) begin
        tail_d = 1'b0;
      end
      count_d = count_inc;
    end
    // token ended: back to the empty-word state
    if (ent.end_v || in_eol_i || (!in_quote_q && (is_op || is_sep)
        && (in_char_i != ChQuote))) begin
      count_d  = '0;
      zero_d   = 1'b0;
      digits_d = 1'b1;
      below8_d = 1'b1;
      tail_d   = 1'b1;
    end
  end

  assign entry_o = ent;
  assign push_o  = accept && (ent.end_v || ent.echo_v || ent.op_v || ent.done_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q      <= SepReset;
      in_quote_q <= 1'b0;
      count_q    <= '0;
      zero_q     <= 1'b0;
      digits_q   <= 1'b1;
      below8_q   <= 1'b1;
      tail_q     <= 1'b1;
    end else begin
      sep_q <= sep_d;
      if (accept) begin
        in_quote_q <= in_quote_d;
        count_q    <= count_d;
        zero_q     <= zero_d;
        digits_q   <= digits_d;
        below8_q   <= below8_d;
        tail_q     <= tail_d;
      end
    end
  end

endmodule

// File: src/etl_fifo.sv
module etl_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  etl_pkg::entry_t    entry_i,
  input  logic               pop_i,
  output etl_pkg::entry_t    entry_o,
  output etl_pkg::q_status_t status_o
);
  import etl_pkg::*;

  entry_t             mem_q [QueueDepth];
  logic [QueueAw:0]   wr_q, wr_d;
  logic [QueueAw:0]   rd_q, rd_d;

  assign status_o.empty = (wr_q == rd_q);
  assign status_o.full  = (wr_q[QueueAw] != rd_q[QueueAw]) &&
                          (wr_q[QueueAw-1:0] == rd_q[QueueAw-1:0]);
  assign entry_o = mem_q[rd_q[QueueAw-1:0]];

  assign wr_d = (push_i && !status_o.full) ? wr_q + 1'b1 : wr_q;
  assign rd_d = (pop_i && !status_o.empty) ? rd_q + 1'b1 : rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !status_o.full) mem_q[wr_q[QueueAw-1:0]] <= entry_i;
  end

endmodule

// File: src/etl_back.sv
module etl_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  etl_pkg::entry_t            entry_i,
  input  etl_pkg::q_status_t         q_status_i,
  output logic                       pop_o,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [etl_pkg::KindW-1:0]  kind_o,
  output logic [etl_pkg::CharW-1:0]  char_o,
  output logic [etl_pkg::ClassW-1:0] class_o,
  output logic [etl_pkg::LenW-1:0]   len_o,
  output logic                       unterm_o,
  output logic                       last_o
);
  import etl_pkg::*;

  // bit 0 word end, 1 echo, 2 operator end, 3 line done
  logic [3:0] sent_q, sent_d;
  logic [3:0] mask, rem, cur;
  logic       fire;

  assign mask    = {entry_i.done_v, entry_i.op_v, entry_i.echo_v, entry_i.end_v};
  assign rem     = mask & ~sent_q;
  assign cur     = rem & (~rem + 4'd1);
  assign last_o  = ((rem & (rem - 4'd1)) == 4'd0);
  assign valid_o = !q_status_i.empty;
  assign fire    = valid_o && ready_i;
  assign pop_o   = fire && last_o;

  always_comb begin
    kind_o   = KindChar;
    char_o   = '0;
    class_o  = ClassInt;
    len_o    = '0;
    unterm_o = 1'b0;
    priority if (cur[0]) begin
      kind_o  = KindEnd;
      class_o = entry_i.end_class;
      len_o   = entry_i.end_len;
    end else if (cur[1]) begin
      char_o = entry_i.ch;
    end else if (cur[2]) begin
      kind_o  = KindEnd;
      class_o = ClassOper;
      len_o   = LenW'(1);
    end else if (cur[3]) begin
      kind_o   = KindDone;
      unterm_o = entry_i.unterm;
    end
  end

  always_comb begin
    sent_d = sent_q;
    if (pop_o)     sent_d = '0;
    else if (fire) sent_d = sent_q | cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sent_q <= '0;
    else         sent_q <= sent_d;
  end

endmodule
